// File: hdl/rcb_pkg.sv
// Shared types, constants and helpers for the rectangle coalescing buffer.
`default_nettype none

package rcb_pkg;

  localparam int STORE_DEPTH_DEF = 16;

  localparam int X_W    = 13;
  localparam int Y_W    = 13;
  localparam int W_W    = 14;
  localparam int H_W    = 14;
  localparam int SPAN_W = 10;
  localparam int SCALE_W = 5;

  localparam logic [W_W-1:0]     SIZE_LIMIT  = 14'd8192;
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 5'd16;
  localparam logic [SPAN_W-1:0]  SPAN_LIMIT  = 10'd512;

  // configuration register indexes
  typedef enum logic {
    CFG_SCALE_X = 1'b0,
    CFG_SCALE_Y = 1'b1
  } cfg_idx_t;

  // input opcode
  typedef enum logic {
    OPC_ADD   = 1'b0,
    OPC_FLUSH = 1'b1
  } opcode_t;

  // one stored rectangle, output units
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [W_W-1:0] w;
    logic [H_W-1:0] h;
  } rect_t;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_MUL   = 3'd1,
    OP_HORZ  = 3'd2,
    OP_VERT  = 3'd3,
    OP_WIDEN = 3'd4,
    OP_GROW  = 3'd5
  } unit_op_t;

  typedef struct packed {
    unit_op_t            op;
    logic [SPAN_W-1:0]   mul_a;
    logic [SCALE_W-1:0]  mul_b;
  } unit_req_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    r = v;
    if (v == '0) r = 5'd1;
    else if (v > SCALE_LIMIT) r = SCALE_LIMIT;
    return r;
  endfunction

  function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_W-1:0] v);
    logic [SPAN_W-1:0] r;
    r = v;
    if (v == '0) r = 10'd1;
    else if (v > SPAN_LIMIT) r = SPAN_LIMIT;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rcb_if.sv
// Valid/ready channel interfaces for span input and rectangle output.
`default_nettype none

interface rcb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [8:0] span_x;
  logic [8:0] span_y;
  logic [9:0] span_w;
  logic [9:0] span_h;

  modport source (output valid, opcode, span_x, span_y, span_w, span_h, input ready);
  modport sink   (input valid, opcode, span_x, span_y, span_w, span_h, output ready);
endinterface

interface rcb_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] rect_x;
  logic [12:0] rect_y;
  logic [13:0] rect_w;
  logic [13:0] rect_h;
  logic        last_of_run;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, last_of_run, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/rcb_store.sv
// Rectangle store: one write port, one registered read port.
`default_nettype none

module rcb_store #(
  parameter int DEPTH = rcb_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] wr_addr,
  input  wire rcb_pkg::rect_t                wr_data,
  input  wire logic                          rd_en,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] rd_addr,
  output rcb_pkg::rect_t                     rd_data
);

  rcb_pkg::rect_t mem [DEPTH];
  rcb_pkg::rect_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/rcb_unit.sv
// Shared arithmetic unit: scale multiply, edge add-and-compare, saturating widen and grow.
`default_nettype none

module rcb_unit (
  input  wire rcb_pkg::unit_req_t req,
  input  wire rcb_pkg::rect_t     entry,
  input  wire rcb_pkg::rect_t     span,
  output logic [rcb_pkg::W_W-1:0] res,
  output logic                    hit
);

  logic [rcb_pkg::W_W:0]   prod;
  logic [rcb_pkg::W_W-1:0] add_a;
  logic [rcb_pkg::W_W-1:0] add_b;
  logic [rcb_pkg::X_W-1:0] target;
  logic                    side_eq;
  logic [rcb_pkg::W_W:0]   sum;
  logic [rcb_pkg::W_W-1:0] sat;

  assign prod = 15'(req.mul_a) * 15'(req.mul_b);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    target  = '0;
    side_eq = 1'b0;
    case (req.op)
      rcb_pkg::OP_HORZ: begin
        // newest ends where the span starts, same row band
        add_a   = {1'b0, entry.x};
        add_b   = entry.w;
        target  = span.x;
        side_eq = (entry.y == span.y) && (entry.h == span.h);
      end
      rcb_pkg::OP_VERT: begin
        // entry bottom touches span top, same column band
        add_a   = {1'b0, entry.y};
        add_b   = entry.h;
        target  = span.y;
        side_eq = (entry.x == span.x) && (entry.w == span.w);
      end
      rcb_pkg::OP_WIDEN: begin
        add_a = entry.w;
        add_b = span.w;
      end
      rcb_pkg::OP_GROW: begin
        add_a = entry.h;
        add_b = span.h;
      end
      default: begin
      end
    endcase
  end

  assign sum = 15'(add_a) + 15'(add_b);
  assign sat = (sum > 15'(rcb_pkg::SIZE_LIMIT)) ? rcb_pkg::SIZE_LIMIT : sum[rcb_pkg::W_W-1:0];

  always_comb begin
    res = '0;
    hit = 1'b0;
    case (req.op)
      rcb_pkg::OP_MUL:   res = prod[rcb_pkg::W_W-1:0];
      rcb_pkg::OP_WIDEN: res = sat;
      rcb_pkg::OP_GROW:  res = sat;
      rcb_pkg::OP_HORZ:  hit = side_eq && (sum == {2'b00, target});
      rcb_pkg::OP_VERT:  hit = side_eq && (sum == {2'b00, target});
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/rectangle_coalescing_buffer.sv
// Top level: sequencer, config registers and output register of the coalescing buffer.
//
// Channel   Dir  Handshake            Payload
// in_chan   in   valid/ready          opcode, span_x, span_y, span_w, span_h
// out_chan  out  valid/ready          rect_x, rect_y, rect_w, rect_h, last_of_run
// cfg_*     in   cfg_we (no wait)     cfg_idx, cfg_wdata (pixel_scale_x / pixel_scale_y)
//
// An add is taken in the idle cycle, then the one shared unit scales x, y, w and h in
// turn; with entries stored it checks the newest for a horizontal merge and, on a miss,
// makes one vertical compare per stored entry (newest first, stopping on a hit) before
// a write that widens, grows or appends. An add that finds the store full and merges
// nowhere also emits the whole store first. A flush or overflow run reads the first
// entry, then emits one rectangle per cycle when the sink takes every transfer; the
// store's single read port sets that pace. in_chan.ready is high only while the
// sequencer is idle, so a new item is taken only after the previous one is finished.
// The output register lets a finished rectangle wait for the sink while a new item is
// taken; a stalled sink holds the emit loop.
// Synchronous active-low reset clears the count, scales (to 1) and control; the
// store itself is not cleared, only entries below the count are ever read.
`default_nettype none

module rectangle_coalescing_buffer #(
  parameter int STORE_DEPTH = rcb_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rcb_in_if.sink                            in_chan,
  rcb_out_if.source                         out_chan,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_idx,
  input  wire logic [rcb_pkg::SCALE_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCALE  = 9'b000000010,
    S_HORZ   = 9'b000000100,
    S_SRCH   = 9'b000001000,
    S_WIDEN  = 9'b000010000,
    S_GROW   = 9'b000100000,
    S_APPEND = 9'b001000000,
    S_EMRD   = 9'b010000000,
    S_EMLD   = 9'b100000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              ptr_r, ptr_nxt;       // search / emit index
  logic [1:0]                    step_r, step_nxt;     // scale step
  logic                          app_pend_r, app_pend_nxt;
  logic [rcb_pkg::SCALE_W-1:0]   scale_x_r, scale_y_r;

  // captured span in source units
  logic [8:0]                    src_x_r, src_x_nxt;
  logic [8:0]                    src_y_r, src_y_nxt;
  logic [rcb_pkg::SPAN_W-1:0]    src_w_r, src_w_nxt;
  logic [rcb_pkg::SPAN_W-1:0]    src_h_r, src_h_nxt;

  // span in output units, built one field per scale step
  rcb_pkg::rect_t                span_r, span_nxt;

  // output register
  rcb_pkg::rect_t                out_r, out_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // store and shared unit hookup
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  rcb_pkg::rect_t                wr_data;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  rcb_pkg::rect_t                rd_data;
  rcb_pkg::unit_req_t            ureq;
  logic [rcb_pkg::W_W-1:0]       ures;
  logic                          uhit;

  logic                          in_xfer;
  logic                          out_free;
  logic                          emit_last;

  rcb_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rcb_unit u_unit (
    .req   (ureq),
    .entry (rd_data),
    .span  (span_r),
    .res   (ures),
    .hit   (uhit)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // output register can take a new rectangle this cycle
  assign out_free  = !out_valid_r || out_chan.ready;
  assign emit_last = (CNT_W'(ptr_r) == count_r - 1'b1);

  // configuration: clamp on write, so the scales are always 1..16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= 5'd1;
      scale_y_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        rcb_pkg::CFG_SCALE_X: scale_x_r <= rcb_pkg::clamp_scale(cfg_wdata);
        rcb_pkg::CFG_SCALE_Y: scale_y_r <= rcb_pkg::clamp_scale(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    step_nxt     = step_r;
    app_pend_nxt = app_pend_r;
    src_x_nxt    = src_x_r;
    src_y_nxt    = src_y_r;
    src_w_nxt    = src_w_r;
    src_h_nxt    = src_h_r;
    span_nxt     = span_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    wr_en        = 1'b0;
    wr_addr      = ptr_r;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = ptr_r;
    ureq.op      = rcb_pkg::OP_NOP;
    ureq.mul_a   = '0;
    ureq.mul_b   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_chan.opcode == rcb_pkg::OPC_FLUSH) begin
            // flush of an empty store gives nothing
            if (count_r != '0) begin
              app_pend_nxt = 1'b0;
              ptr_nxt      = '0;
              state_nxt    = S_EMRD;
            end
          end else begin
            src_x_nxt = in_chan.span_x;
            src_y_nxt = in_chan.span_y;
            src_w_nxt = rcb_pkg::clamp_span(in_chan.span_w);
            src_h_nxt = rcb_pkg::clamp_span(in_chan.span_h);
            step_nxt  = '0;
            state_nxt = S_SCALE;
          end
        end
      end

      S_SCALE: begin
        ureq.op = rcb_pkg::OP_MUL;
        case (step_r)
          2'd0: begin
            ureq.mul_a = {1'b0, src_x_r};
            ureq.mul_b = scale_x_r;
            span_nxt.x = ures[rcb_pkg::X_W-1:0];
          end
          2'd1: begin
            ureq.mul_a = {1'b0, src_y_r};
            ureq.mul_b = scale_y_r;
            span_nxt.y = ures[rcb_pkg::Y_W-1:0];
          end
          2'd2: begin
            ureq.mul_a = src_w_r;
            ureq.mul_b = scale_x_r;
            span_nxt.w = ures;
          end
          default: begin
            ureq.mul_a = src_h_r;
            ureq.mul_b = scale_y_r;
            span_nxt.h = ures;
          end
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (count_r == '0) begin
            state_nxt = S_APPEND;
          end else begin
            // fetch the newest entry
            ptr_nxt   = IDX_W'(count_r - 1'b1);
            rd_en     = 1'b1;
            rd_addr   = IDX_W'(count_r - 1'b1);
            state_nxt = S_HORZ;
          end
        end
      end

      S_HORZ: begin
        ureq.op = rcb_pkg::OP_HORZ;
        state_nxt = uhit ? S_WIDEN : S_SRCH;
      end

      S_SRCH: begin
        // newest to oldest; read of the next entry only on a miss
        ureq.op = rcb_pkg::OP_VERT;
        if (uhit) begin
          state_nxt = S_GROW;
        end else if (ptr_r == '0) begin
          if (count_r >= CNT_W'(STORE_DEPTH)) begin
            app_pend_nxt = 1'b1;
            state_nxt    = S_EMRD;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_r - 1'b1;
          ptr_nxt   = ptr_r - 1'b1;
        end
      end

      S_WIDEN: begin
        ureq.op   = rcb_pkg::OP_WIDEN;
        wr_en     = 1'b1;
        wr_data   = rd_data;
        wr_data.w = ures;
        state_nxt = S_IDLE;
      end

      S_GROW: begin
        ureq.op   = rcb_pkg::OP_GROW;
        wr_en     = 1'b1;
        wr_data   = rd_data;
        wr_data.h = ures;
        state_nxt = S_IDLE;
      end

      S_APPEND: begin
        wr_en        = 1'b1;
        wr_addr      = IDX_W'(count_r);
        wr_data      = span_r;
        count_nxt    = count_r + 1'b1;
        app_pend_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      S_EMRD: begin
        rd_en     = 1'b1;
        rd_addr   = ptr_r;
        state_nxt = S_EMLD;
      end

      S_EMLD: begin
        // one rectangle per cycle while the sink keeps up
        if (out_free) begin
          out_nxt       = rd_data;
          out_last_nxt  = emit_last;
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            count_nxt = '0;
            state_nxt = app_pend_r ? S_APPEND : S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_r + 1'b1;
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      step_r      <= '0;
      app_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      step_r      <= step_nxt;
      app_pend_r  <= app_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_x_r    <= src_x_nxt;
    src_y_r    <= src_y_nxt;
    src_w_r    <= src_w_nxt;
    src_h_r    <= src_h_nxt;
    span_r     <= span_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.rect_x      = out_r.x;
  assign out_chan.rect_y      = out_r.y;
  assign out_chan.rect_w      = out_r.w;
  assign out_chan.rect_h      = out_r.h;
  assign out_chan.last_of_run = out_last_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("store count above depth");

  a_ptr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_HORZ || state_r == S_EMLD) |->
      (CNT_W'(ptr_r) < count_r))
    else $error("store index at or past count");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPEND) |-> (count_r < CNT_W'(STORE_DEPTH)))
    else $error("append into a full store");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMLD && out_free && emit_last) |=> (count_r == '0))
    else $error("store not emptied after last rectangle");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    (scale_x_r != '0) && (scale_x_r <= rcb_pkg::SCALE_LIMIT) &&
    (scale_y_r != '0) && (scale_y_r <= rcb_pkg::SCALE_LIMIT))
    else $error("pixel scale out of range");

endmodule

`default_nettype wire
